// ===== rtl/gtcr_pkg.sv =====
package gtcr_pkg;

  localparam int LINE_WIDTH_DEF    = 128;
  localparam int FRAME_COLUMNS_DEF = 512;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int FONT_SIZE         = 27;
  localparam int GLYPH_COLS        = 5;

  typedef enum logic [1:0] {
    CMD_CHAR  = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_FRAME = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    JOB_GLYPH = 2'd0,
    JOB_FILL  = 2'd1,
    JOB_FRAME = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [2:0]  pads;
    logic        spacer;
    logic [4:0]  glyph;
    logic [2:0]  width;
  } job_t;

  localparam logic [2:0] FONT_WIDTH [FONT_SIZE] = '{
    3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3,
    3'd4, 3'd4, 3'd4, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd4, 3'd5, 3'd5, 3'd4, 3'd5, 3'd4
  };

  localparam logic [7:0] FONT_COLS [FONT_SIZE][GLYPH_COLS] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3C, 8'h50, 8'h50, 8'h3C, 8'h00},
    '{8'h7C, 8'h54, 8'h54, 8'h28, 8'h00},
    '{8'h38, 8'h44, 8'h44, 8'h28, 8'h00},
    '{8'h7C, 8'h44, 8'h44, 8'h38, 8'h00},
    '{8'h7C, 8'h54, 8'h54, 8'h44, 8'h00},
    '{8'h7C, 8'h50, 8'h50, 8'h40, 8'h00},
    '{8'h38, 8'h44, 8'h54, 8'h18, 8'h00},
    '{8'h7C, 8'h10, 8'h10, 8'h7C, 8'h00},
    '{8'h44, 8'h7C, 8'h44, 8'h00, 8'h00},
    '{8'h08, 8'h04, 8'h04, 8'h78, 8'h00},
    '{8'h7C, 8'h10, 8'h28, 8'h44, 8'h00},
    '{8'h7C, 8'h04, 8'h04, 8'h04, 8'h00},
    '{8'h7C, 8'h20, 8'h10, 8'h20, 8'h7C},
    '{8'h7C, 8'h20, 8'h10, 8'h7C, 8'h00},
    '{8'h38, 8'h44, 8'h44, 8'h38, 8'h00},
    '{8'h7C, 8'h50, 8'h50, 8'h20, 8'h00},
    '{8'h38, 8'h44, 8'h48, 8'h34, 8'h00},
    '{8'h7C, 8'h50, 8'h58, 8'h24, 8'h00},
    '{8'h24, 8'h54, 8'h54, 8'h48, 8'h00},
    '{8'h40, 8'h40, 8'h7C, 8'h40, 8'h40},
    '{8'h78, 8'h04, 8'h04, 8'h78, 8'h00},
    '{8'h60, 8'h18, 8'h04, 8'h18, 8'h60},
    '{8'h7C, 8'h08, 8'h10, 8'h08, 8'h7C},
    '{8'h6C, 8'h10, 8'h10, 8'h6C, 8'h00},
    '{8'h60, 8'h10, 8'h1C, 8'h10, 8'h60},
    '{8'h4C, 8'h54, 8'h64, 8'h44, 8'h00}
  };

  function automatic logic [2:0] glyph_width(input logic [4:0] g);
    logic [2:0] w;
    w = 3'd0;
    if (int'(g) < FONT_SIZE) w = FONT_WIDTH[g];
    return w;
  endfunction

  function automatic logic [7:0] glyph_col(input logic [4:0] g, input logic [2:0] k);
    logic [7:0] c;
    c = 8'h00;
    if (int'(g) < FONT_SIZE && int'(k) < GLYPH_COLS) c = FONT_COLS[g][k];
    return c;
  endfunction

endpackage

// ===== rtl/gtcr_in_if.sv =====
interface gtcr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] char_code;

  modport source(output valid, command, char_code, input ready);
  modport sink(input valid, command, char_code, output ready);
endinterface

// ===== rtl/gtcr_out_if.sv =====
interface gtcr_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] column_index;
  logic [7:0] column_bits;
  logic       last_of_run;
  logic       frame_done;
  logic       overflow;

  modport source(output valid, column_index, column_bits, last_of_run, frame_done,
                 overflow, input ready);
  modport sink(input valid, column_index, column_bits, last_of_run, frame_done,
               overflow, output ready);
endinterface

// ===== rtl/glyph_text_column_renderer_unit.sv =====
// channel   dir  modport  payload
// chars     in   sink     command[1:0], char_code[7:0]
// columns   out  source   column_index[8:0], column_bits[7:0], last_of_run,
//                         frame_done, overflow
//
// The front takes one item per cycle while the job queue has room; unknown codes and
// unused commands are dropped there. The back emits one column per cycle while a job is
// queued and the output is free: a character gives pads + spacer + glyph width columns
// (3 to 10), a fill one, a new frame none; columns past the frame end are not sent.
// rst is synchronous; it clears the queue, the line count, frame cursor and overflow flag.
// A stalled columns beat holds in the output register and holds the back; the front
// keeps filling the queue until it is full, then drops ready.
module glyph_text_column_renderer_unit #(
  parameter int LINE_WIDTH    = gtcr_pkg::LINE_WIDTH_DEF,
  parameter int FRAME_COLUMNS = gtcr_pkg::FRAME_COLUMNS_DEF,
  parameter int QUEUE_DEPTH   = gtcr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gtcr_in_if.sink    chars,
  gtcr_out_if.source columns
);

  logic           push;
  gtcr_pkg::job_t push_job;
  logic           full;
  logic           head_valid;
  gtcr_pkg::job_t head;
  logic           pop;

  gtcr_front #(.LINE_WIDTH(LINE_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  gtcr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  gtcr_back #(.FRAME_COLUMNS(FRAME_COLUMNS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .columns    (columns)
  );

endmodule

// ===== rtl/gtcr_front.sv =====
module gtcr_front #(
  parameter int LINE_WIDTH = gtcr_pkg::LINE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  gtcr_in_if.sink       chars,
  output logic          push,
  output gtcr_pkg::job_t push_job,
  input  logic          full
);

  localparam int LR_W = $clog2(LINE_WIDTH + 1);
  localparam logic [LR_W-1:0] LW = LR_W'(LINE_WIDTH);

  logic [LR_W-1:0] line_remaining;
  logic [LR_W-1:0] line_remaining_next;
  logic            accept;
  logic            known;
  logic [4:0]      glyph;
  logic [2:0]      width;
  logic            wrap;
  logic            spacer;
  logic [LR_W-1:0] rest;

  assign chars.ready = !full;
  assign accept      = chars.valid && chars.ready;

  always_comb begin
    known = 1'b0;
    glyph = 5'd0;
    if (chars.char_code == 8'h20) begin
      known = 1'b1;
    end else if (chars.char_code inside {[8'h41:8'h5A]}) begin
      known = 1'b1;
      glyph = 5'(chars.char_code - 8'h40);
    end
  end

  always_comb begin
    width  = gtcr_pkg::glyph_width(glyph);
    wrap   = line_remaining < (LR_W'(width) + LR_W'(1));
    spacer = !wrap && (line_remaining != LW);
    rest   = line_remaining - LR_W'(spacer) - LR_W'(width);

    push                = 1'b0;
    push_job.kind       = gtcr_pkg::JOB_GLYPH;
    push_job.pads       = wrap ? line_remaining[2:0] : 3'd0;
    push_job.spacer     = spacer;
    push_job.glyph      = glyph;
    push_job.width      = width;
    line_remaining_next = line_remaining;

    case (gtcr_pkg::cmd_t'(chars.command))
      gtcr_pkg::CMD_CHAR: begin
        if (known) begin
          push = accept;
          if (wrap) line_remaining_next = LW - LR_W'(width);
          else      line_remaining_next = (rest == '0) ? LW : rest;
        end
      end
      gtcr_pkg::CMD_FILL: begin
        push          = accept;
        push_job.kind = gtcr_pkg::JOB_FILL;
        line_remaining_next = (line_remaining == LR_W'(1)) ? LW
                                                           : line_remaining - LR_W'(1);
      end
      gtcr_pkg::CMD_FRAME: begin
        push                = accept;
        push_job.kind       = gtcr_pkg::JOB_FRAME;
        line_remaining_next = LW;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_remaining <= LW;
    end else if (push) begin
      line_remaining <= line_remaining_next;
    end
  end

endmodule

// ===== rtl/gtcr_queue.sv =====
module gtcr_queue #(
  parameter int DEPTH = gtcr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gtcr_pkg::job_t push_job,
  output logic           full,
  output logic           head_valid,
  output gtcr_pkg::job_t head,
  input  logic           pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gtcr_pkg::job_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

// ===== rtl/gtcr_back.sv =====
module gtcr_back #(
  parameter int FRAME_COLUMNS = gtcr_pkg::FRAME_COLUMNS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  gtcr_pkg::job_t head,
  output logic           pop,
  gtcr_out_if.source     columns
);

  localparam int FC_W = $clog2(FRAME_COLUMNS + 1);

  logic [FC_W-1:0] cursor;
  logic            ovf;
  logic [3:0]      cnt;
  logic            o_valid;
  logic [8:0]      o_index;
  logic [7:0]      o_bits;
  logic            o_last;
  logic            o_done;
  logic            o_ovf;

  logic [3:0] pre;
  logic [3:0] total;
  logic [3:0] glyph_k;
  logic       final_col;
  logic       in_frame;
  logic       at_end;
  logic [7:0] bits;
  logic       step;

  always_comb begin
    pre       = {1'b0, head.pads} + {3'b000, head.spacer};
    total     = (head.kind == gtcr_pkg::JOB_GLYPH) ? pre + {1'b0, head.width} : 4'd1;
    glyph_k   = cnt - pre;
    final_col = cnt == total - 4'd1;
    in_frame  = cursor < FC_W'(FRAME_COLUMNS);
    at_end    = cursor == FC_W'(FRAME_COLUMNS - 1);
    bits      = (head.kind == gtcr_pkg::JOB_GLYPH && cnt >= pre)
                ? gtcr_pkg::glyph_col(head.glyph, glyph_k[2:0]) : 8'h00;
    step      = head_valid && (!o_valid || columns.ready);
    pop       = step && final_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor  <= '0;
      ovf     <= 1'b0;
      cnt     <= '0;
      o_valid <= 1'b0;
    end else begin
      if (o_valid && columns.ready) o_valid <= 1'b0;
      if (step) begin
        cnt <= final_col ? 4'd0 : cnt + 4'd1;
        case (head.kind)
          gtcr_pkg::JOB_FRAME: begin
            cursor <= '0;
            ovf    <= 1'b0;
          end
          default: begin
            if (in_frame) begin
              o_valid <= 1'b1;
              o_index <= 9'(cursor);
              o_bits  <= bits;
              o_last  <= final_col || at_end;
              o_done  <= at_end;
              o_ovf   <= ovf;
              cursor  <= cursor + FC_W'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign columns.valid        = o_valid;
  assign columns.column_index = o_index;
  assign columns.column_bits  = o_bits;
  assign columns.last_of_run  = o_last;
  assign columns.frame_done   = o_done;
  assign columns.overflow     = o_ovf;

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor <= FC_W'(FRAME_COLUMNS))
    else $error("frame cursor past frame end");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> cursor == FC_W'(FRAME_COLUMNS))
    else $error("overflow flag set with room left in frame");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> cnt < total)
    else $error("column counter past end of job");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_done |-> o_last)
    else $error("frame end column not marked last of run");

  a_pop_resets: assert property (@(posedge clk) disable iff (rst)
    pop |=> cnt == 4'd0)
    else $error("column counter not cleared after job");

endmodule
